FILE: rtl/core/image_block_downscaler_defines.svh
// assertion macros shared by the block
`ifndef IMAGE_BLOCK_DOWNSCALER_DEFINES_SVH
`define IMAGE_BLOCK_DOWNSCALER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define DSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dsc_pkg.sv
package dsc_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_FACTOR  = 16;
	localparam int SUM_ENTRIES = MAX_WIDTH / 2;
	localparam int ADDR_W      = $clog2(SUM_ENTRIES);
	localparam int COL_W       = 12;
	localparam int ROW_W       = 13;
	localparam int OUT_DIM_W   = 12;
	localparam int BLK_W       = 4;
	localparam int FAC_W       = 5;
	localparam int DIM_W       = 13;
	localparam int SUM_W       = 16;
	localparam int PIX_W       = 8;
	localparam int NUM_CH      = 3;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 24;
	localparam int DIV_STEPS   = DIM_W;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	typedef enum logic [1:0] {
		REG_SCALE,
		REG_COLOR,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	typedef enum logic {
		RC_IDLE,
		RC_RUN
	} rc_state_t;

	typedef enum logic [1:0] {
		JOB_COL,
		JOB_ROW,
		JOB_WIDTH,
		JOB_HEIGHT
	} job_t;

	// effective configuration, already clamped
	typedef struct packed {
		logic [FAC_W-1:0] factor;
		logic             rgb;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	// block geometry from the recompute unit
	typedef struct packed {
		logic                 busy;
		logic                 load;
		logic [ADDR_W-1:0]    ocol;
		logic [BLK_W-1:0]     cib;
		logic [OUT_DIM_W-1:0] orow;
		logic [BLK_W-1:0]     rib;
		logic [OUT_DIM_W-1:0] out_w;
		logic [OUT_DIM_W-1:0] out_h;
	} geom_t;

	// finished block sums on their way to normalization
	typedef struct packed {
		logic [NUM_CH-1:0][SUM_W-1:0] sums;
		logic                         row_end;
		logic                         frame_end;
	} sum_beat_t;

	// reciprocal of the block divisor, scaled by 2^RECIP_SHIFT and rounded up
	function automatic logic [RECIP_W-1:0] recip(input logic [FAC_W-1:0] f);
		logic [RECIP_W-1:0] m;
		unique case (f)
			5'd2:    m = 23'd4194304;
			5'd3:    m = 23'd1048576;
			5'd4:    m = 23'd1048576;
			5'd6:    m = 23'd466034;
			5'd8:    m = 23'd262144;
			5'd10:   m = 23'd167773;
			5'd12:   m = 23'd116509;
			5'd14:   m = 23'd85599;
			5'd16:   m = 23'd65536;
			default: m = '0;
		endcase
		return m;
	endfunction

	// binomial weight as a shift: middle row and column each double
	function automatic logic [1:0] kern_shift(input logic [BLK_W-1:0] cib,
			input logic [BLK_W-1:0] rib);
		logic [1:0] c;
		logic [1:0] r;
		c = (cib == BLK_W'(1)) ? 2'd1 : 2'd0;
		r = (rib == BLK_W'(1)) ? 2'd1 : 2'd0;
		return c + r;
	endfunction

endpackage

FILE: rtl/core/dsc_if.sv
interface dsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_or_gray;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, red_or_gray, green_in, blue_in, input ready);
	modport sink (input valid, red_or_gray, green_in, blue_in, output ready);
endinterface

interface dsc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red_or_gray;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       row_end;
	logic       frame_end;

	modport source (output valid, out_red_or_gray, out_green, out_blue, row_end,
		frame_end, input ready);
	modport sink (input valid, out_red_or_gray, out_green, out_blue, row_end,
		frame_end, output ready);
endinterface

FILE: rtl/core/image_block_downscaler.sv
// a block's result passes the accumulation, scale and output registers after its last pixel
// one pixel per cycle unless stalled; column sum memory is read-modify-write with forwarding
// each register write stalls input while the serial divider recomputes
//   block position and output size (four 13-step divisions)
// reset restores the register defaults and clears the position; column sums are not cleared
`include "image_block_downscaler_defines.svh"

module image_block_downscaler (
	input  logic                       clk,
	input  logic                       arst_n,
	dsc_in_if.sink                     pix_in,
	dsc_out_if.source                  pix_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dsc_pkg::APB_AW-1:0] paddr,
	input  logic [dsc_pkg::APB_DW-1:0] pwdata,
	output logic [dsc_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import dsc_pkg::*;

	cfg_t             cfg;
	logic             cfg_wr;
	geom_t            geom;
	logic [COL_W-1:0] col_pos;
	logic [ROW_W-1:0] row_pos;
	logic             beat_valid;
	logic             beat_ready;
	sum_beat_t        beat;

	dsc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	dsc_recalc u_recalc (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr),
		.col_pos (col_pos),
		.row_pos (row_pos),
		.geom    (geom)
	);

	dsc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.geom       (geom),
		.pix_in     (pix_in),
		.col_pos    (col_pos),
		.row_pos    (row_pos),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat)
	);

	dsc_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat),
		.pix_out    (pix_out)
	);

	// checks
	`DSC_ASSERT_NOW(a_no_accept_busy, pix_in.valid && pix_in.ready, !geom.busy, "pixel taken during recompute")
	`DSC_ASSERT_NEXT(a_wr_starts_recalc, cfg_wr, geom.busy, "register write did not start recompute")
	`DSC_ASSERT_NEXT(a_load_ends_recalc, geom.load && !cfg_wr, !geom.busy, "recompute still busy after load")
	`DSC_ASSERT_NOW(a_frame_end_row_end, pix_out.valid && pix_out.frame_end, pix_out.row_end, "frame end without row end")

endmodule

FILE: rtl/core/dsc_cfg_regs.sv
module dsc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dsc_pkg::APB_AW-1:0] paddr,
	input  logic [dsc_pkg::APB_DW-1:0] pwdata,
	output logic [dsc_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output dsc_pkg::cfg_t              cfg,
	output logic                       cfg_wr
);
	import dsc_pkg::*;

	logic [FAC_W-1:0] scale_q;
	logic             color_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	reg_idx_t         idx;
	logic             aligned;

	assign pready  = 1'b1;
	assign idx     = reg_idx_t'(paddr[3:2]);
	assign aligned = (paddr[1:0] == 2'b00);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= FAC_W'(2);
			color_q  <= 1'b0;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_wr && aligned) begin
			unique case (idx)
				REG_SCALE:  scale_q  <= pwdata[FAC_W-1:0];
				REG_COLOR:  color_q  <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (aligned) begin
			unique case (idx)
				REG_SCALE:  prdata = APB_DW'(scale_q);
				REG_COLOR:  prdata = APB_DW'(color_q);
				REG_WIDTH:  prdata = APB_DW'(width_q);
				REG_HEIGHT: prdata = APB_DW'(height_q);
			endcase
		end
	end

	// clamp to the usable range
	always_comb begin
		priority if (scale_q < FAC_W'(2))
			cfg.factor = FAC_W'(2);
		else if (scale_q > FAC_W'(MAX_FACTOR))
			cfg.factor = FAC_W'(MAX_FACTOR);
		else
			cfg.factor = scale_q;
		priority if (width_q == '0)
			cfg.width = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH))
			cfg.width = DIM_W'(MAX_WIDTH);
		else
			cfg.width = width_q;
		cfg.height = (height_q == '0) ? DIM_W'(1) : height_q;
		cfg.rgb    = color_q;
	end

endmodule

FILE: rtl/core/dsc_recalc.sv
module dsc_recalc (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dsc_pkg::cfg_t             cfg,
	input  logic                      cfg_wr,
	input  logic [dsc_pkg::COL_W-1:0] col_pos,
	input  logic [dsc_pkg::ROW_W-1:0] row_pos,
	output dsc_pkg::geom_t            geom
);
	import dsc_pkg::*;

	rc_state_t            state_q;
	rc_state_t            state_d;
	job_t                 job_q;
	job_t                 job_next;
	logic [3:0]           bit_q;
	logic [DIM_W-1:0]     dvd_q;
	logic [BLK_W-1:0]     rem_q;
	logic [DIM_W-1:0]     quot_q;
	logic [FAC_W-1:0]     shifted;
	logic                 ge;
	logic [BLK_W-1:0]     rem_n;
	logic [DIM_W-1:0]     quot_n;
	logic                 job_done;
	logic [ADDR_W-1:0]    ocol_q;
	logic [BLK_W-1:0]     cib_q;
	logic [OUT_DIM_W-1:0] orow_q;
	logic [BLK_W-1:0]     rib_q;
	logic [OUT_DIM_W-1:0] out_w_q;
	logic [OUT_DIM_W-1:0] out_h_q;
	logic                 busy;
	logic                 load;

	// dividend for each job
	function automatic logic [DIM_W-1:0] dividend(input job_t j, input cfg_t c,
			input logic [COL_W-1:0] cp, input logic [ROW_W-1:0] rp);
		logic [DIM_W-1:0] d;
		unique case (j)
			JOB_COL:    d = DIM_W'(cp);
			JOB_ROW:    d = rp;
			JOB_WIDTH:  d = c.width;
			JOB_HEIGHT: d = c.height;
		endcase
		return d;
	endfunction

	// one restoring division step
	assign shifted  = {rem_q, dvd_q[DIM_W-1]};
	assign ge       = (shifted >= cfg.factor);
	assign rem_n    = ge ? BLK_W'(shifted - cfg.factor) : shifted[BLK_W-1:0];
	assign quot_n   = {quot_q[DIM_W-2:0], ge};
	assign job_done = (bit_q == 4'(DIV_STEPS - 1));

	always_comb begin
		unique case (job_q)
			JOB_COL:    job_next = JOB_ROW;
			JOB_ROW:    job_next = JOB_WIDTH;
			JOB_WIDTH:  job_next = JOB_HEIGHT;
			JOB_HEIGHT: job_next = JOB_COL;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RC_IDLE: if (cfg_wr) state_d = RC_RUN;
			RC_RUN: begin
				if (!cfg_wr && job_done && job_q == JOB_HEIGHT)
					state_d = RC_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b0;
		load = 1'b0;
		unique case (state_q)
			RC_IDLE: busy = 1'b0;
			RC_RUN: begin
				busy = 1'b1;
				load = !cfg_wr && job_done && (job_q == JOB_HEIGHT);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= RC_IDLE;
		else
			state_q <= state_d;
	end

	// division sequencer, four jobs of one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q   <= JOB_COL;
			bit_q   <= '0;
			ocol_q  <= '0;
			cib_q   <= '0;
			orow_q  <= '0;
			rib_q   <= '0;
			out_w_q <= '0;
			out_h_q <= '0;
		end else if (cfg_wr) begin
			job_q <= JOB_COL;
			bit_q <= '0;
		end else if (state_q == RC_RUN) begin
			if (job_done) begin
				unique case (job_q)
					JOB_COL: begin
						ocol_q <= quot_n[ADDR_W-1:0];
						cib_q  <= rem_n;
					end
					JOB_ROW: begin
						orow_q <= quot_n[OUT_DIM_W-1:0];
						rib_q  <= rem_n;
					end
					JOB_WIDTH:  out_w_q <= quot_n[OUT_DIM_W-1:0];
					JOB_HEIGHT: out_h_q <= quot_n[OUT_DIM_W-1:0];
				endcase
				job_q <= job_next;
				bit_q <= '0;
			end else begin
				bit_q <= bit_q + 4'd1;
			end
		end
	end

	// datapath of the divider
	always_ff @(posedge clk) begin
		if (cfg_wr) begin
			dvd_q  <= dividend(JOB_COL, cfg, col_pos, row_pos);
			rem_q  <= '0;
			quot_q <= '0;
		end else if (job_done) begin
			dvd_q  <= dividend(job_next, cfg, col_pos, row_pos);
			rem_q  <= '0;
			quot_q <= '0;
		end else begin
			dvd_q  <= {dvd_q[DIM_W-2:0], 1'b0};
			rem_q  <= rem_n;
			quot_q <= quot_n;
		end
	end

	always_comb begin
		geom.busy  = busy;
		geom.load  = load;
		geom.ocol  = ocol_q;
		geom.cib   = cib_q;
		geom.orow  = orow_q;
		geom.rib   = rib_q;
		geom.out_w = out_w_q;
		geom.out_h = out_h_q;
	end

endmodule

FILE: rtl/core/dsc_accum.sv
module dsc_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dsc_pkg::cfg_t             cfg,
	input  dsc_pkg::geom_t            geom,
	dsc_in_if.sink                    pix_in,
	output logic [dsc_pkg::COL_W-1:0] col_pos,
	output logic [dsc_pkg::ROW_W-1:0] row_pos,
	output logic                      beat_valid,
	input  logic                      beat_ready,
	output dsc_pkg::sum_beat_t        beat
);
	import dsc_pkg::*;

	localparam int MEM_W = NUM_CH * SUM_W;

	logic [MEM_W-1:0]     mem [SUM_ENTRIES];
	logic [MEM_W-1:0]     rdata_q;

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [ADDR_W-1:0]    ocol_q;
	logic [BLK_W-1:0]     cib_q;
	logic [OUT_DIM_W-1:0] orow_q;
	logic [BLK_W-1:0]     rib_q;

	logic                 s1_valid_q;
	logic                 s1_inblk;
	logic                 s1_first;
	logic                 s1_emit;
	logic                 s1_row_end;
	logic                 s1_frame_end;
	logic                 s1_fwd;
	logic [MEM_W-1:0]     s1_fwd_data;
	logic [ADDR_W-1:0]    s1_addr;
	logic [1:0]           s1_shift;
	logic [NUM_CH-1:0][PIX_W-1:0] s1_px;

	logic                 accept;
	logic                 s1_adv;
	logic                 wr_en;
	logic                 in_blk;
	logic                 last_c;
	logic                 last_r;
	logic                 col_wrap;
	logic                 row_wrap;
	logic [MEM_W-1:0]     base;
	logic [MEM_W-1:0]     new_sum;
	logic [FAC_W-1:0]     fm1;

	assign fm1      = cfg.factor - FAC_W'(1);
	assign in_blk   = (OUT_DIM_W'(ocol_q) < geom.out_w) && (orow_q < geom.out_h);
	assign last_c   = (FAC_W'(cib_q) == fm1);
	assign last_r   = (FAC_W'(rib_q) == fm1);
	assign col_wrap = (DIM_W'(col_q) + DIM_W'(1) >= cfg.width);
	assign row_wrap = (row_q + ROW_W'(1) >= cfg.height);

	// handshake: the stage drains unless a result has nowhere to go
	assign s1_adv       = !s1_valid_q || !s1_emit || beat_ready;
	assign pix_in.ready = !geom.busy && s1_adv;
	assign accept       = pix_in.valid && pix_in.ready;
	assign wr_en        = s1_valid_q && s1_inblk && s1_adv;

	assign col_pos = col_q;
	assign row_pos = row_q;

	// raster position and position inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			cib_q  <= '0;
			orow_q <= '0;
			rib_q  <= '0;
		end else if (geom.load) begin
			ocol_q <= geom.ocol;
			cib_q  <= geom.cib;
			orow_q <= geom.orow;
			rib_q  <= geom.rib;
		end else if (accept) begin
			if (col_wrap) begin
				col_q  <= '0;
				ocol_q <= '0;
				cib_q  <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					orow_q <= '0;
					rib_q  <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					if (last_r) begin
						rib_q  <= '0;
						orow_q <= orow_q + OUT_DIM_W'(1);
					end else begin
						rib_q <= rib_q + BLK_W'(1);
					end
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				if (last_c) begin
					cib_q  <= '0;
					ocol_q <= ocol_q + ADDR_W'(1);
				end else begin
					cib_q <= cib_q + BLK_W'(1);
				end
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s1_adv)
			s1_valid_q <= accept;
	end

	// stage payload, with forwarding of a write to the entry being read
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_addr      <= ocol_q;
			s1_inblk     <= in_blk;
			s1_first     <= (cib_q == '0) && (rib_q == '0);
			s1_emit      <= in_blk && last_c && last_r;
			s1_row_end   <= (OUT_DIM_W'(ocol_q) == geom.out_w - OUT_DIM_W'(1));
			s1_frame_end <= (OUT_DIM_W'(ocol_q) == geom.out_w - OUT_DIM_W'(1))
				&& (orow_q == geom.out_h - OUT_DIM_W'(1));
			s1_shift     <= (cfg.factor == FAC_W'(3)) ? kern_shift(cib_q, rib_q) : 2'd0;
			s1_px[0]     <= pix_in.red_or_gray;
			s1_px[1]     <= cfg.rgb ? pix_in.green_in : '0;
			s1_px[2]     <= cfg.rgb ? pix_in.blue_in : '0;
			s1_fwd       <= wr_en && (s1_addr == ocol_q);
			s1_fwd_data  <= new_sum;
		end
	end

	// column sum memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[s1_addr] <= new_sum;
		if (accept)
			rdata_q <= mem[ocol_q];
	end

	// read-modify-write of the block sums
	always_comb begin
		if (s1_first)
			base = '0;
		else if (s1_fwd)
			base = s1_fwd_data;
		else
			base = rdata_q;
		for (int k = 0; k < NUM_CH; k++) begin
			new_sum[k*SUM_W +: SUM_W] = base[k*SUM_W +: SUM_W]
				+ (SUM_W'(s1_px[k]) << s1_shift);
		end
	end

	assign beat_valid = s1_valid_q && s1_emit;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++)
			beat.sums[k] = new_sum[k*SUM_W +: SUM_W];
		beat.row_end   = s1_row_end;
		beat.frame_end = s1_frame_end;
	end

endmodule

FILE: rtl/core/dsc_scale.sv
module dsc_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  dsc_pkg::cfg_t      cfg,
	input  logic               beat_valid,
	output logic               beat_ready,
	input  dsc_pkg::sum_beat_t beat,
	dsc_out_if.source          pix_out
);
	import dsc_pkg::*;

	localparam int PROD_W = SUM_W + RECIP_W;

	logic                              s2_valid_q;
	sum_beat_t                         s2_beat;
	logic                              out_valid_q;
	logic [NUM_CH-1:0][PIX_W-1:0]      out_px_q;
	logic                              out_row_end_q;
	logic                              out_frame_end_q;
	logic                              out_free;
	logic [RECIP_W-1:0]                m;
	logic [NUM_CH-1:0][PROD_W-1:0]     prod;

	assign out_free   = !out_valid_q || pix_out.ready;
	assign beat_ready = !s2_valid_q || out_free;
	assign m          = recip(cfg.factor);

	// divide by the block weight through its reciprocal
	always_comb begin
		for (int k = 0; k < NUM_CH; k++)
			prod[k] = PROD_W'(s2_beat.sums[k]) * PROD_W'(m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (beat_ready)
				s2_valid_q <= beat_valid;
			if (out_free)
				out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_ready && beat_valid)
			s2_beat <= beat;
		if (out_free && s2_valid_q) begin
			for (int k = 0; k < NUM_CH; k++)
				out_px_q[k] <= prod[k][RECIP_SHIFT +: PIX_W];
			out_row_end_q   <= s2_beat.row_end;
			out_frame_end_q <= s2_beat.frame_end;
		end
	end

	assign pix_out.valid           = out_valid_q;
	assign pix_out.out_red_or_gray = out_px_q[0];
	assign pix_out.out_green       = out_px_q[1];
	assign pix_out.out_blue        = out_px_q[2];
	assign pix_out.row_end         = out_row_end_q;
	assign pix_out.frame_end       = out_frame_end_q;

endmodule
